// ===== src/tsl_pkg.sv =====
// ----------------------------------------------------------------------------
// tsl_pkg
// shared constants, types and the quarter-wave sine table function for the
// tempo synced lfo
// ----------------------------------------------------------------------------
package tsl_pkg;

    localparam int unsigned SINE_ADDR_BITS_DEF = 10;
    localparam int unsigned MAG_BITS           = 15;
    localparam int unsigned VALUE_BITS         = 16;
    localparam int unsigned PHASE_BITS         = 32;
    localparam int unsigned STEP_BITS          = 31;
    localparam int unsigned RAMP_BITS          = 8;
    localparam int unsigned MODE_BITS          = 3;
    localparam int unsigned CFG_INDEX_BITS     = 2;
    localparam int unsigned CFG_DATA_BITS      = 31;

    // register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_RATE_MODE    = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PHASE_STEP   = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_RAMP_SAMPLES = 2'd2;

    // rate modes
    localparam logic [MODE_BITS-1:0] MODE_FREE      = 3'd0;
    localparam logic [MODE_BITS-1:0] MODE_WHOLE     = 3'd1;
    localparam logic [MODE_BITS-1:0] MODE_HALF      = 3'd2;
    localparam logic [MODE_BITS-1:0] MODE_QUARTER   = 3'd3;
    localparam logic [MODE_BITS-1:0] MODE_EIGHTH    = 3'd4;
    localparam logic [MODE_BITS-1:0] MODE_SIXTEENTH = 3'd5;

    localparam logic [STEP_BITS-1:0]  PHASE_STEP_RESET   = 31'd97391;
    localparam logic [RAMP_BITS-1:0]  RAMP_SAMPLES_RESET = 8'd22;
    localparam logic [VALUE_BITS-1:0] FULL_SCALE         = 16'd32767;

    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam int unsigned TAYLOR_TERMS = 6;
    // (2k)(2k+1) for k = 1 .. 6
    localparam longint TAYLOR_DIV [TAYLOR_TERMS] = '{6, 20, 42, 72, 110, 156};

    typedef struct packed {
        logic start;
        logic cancel;
    } div_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    // sine magnitude of table entry idx, evaluated at elaboration only
    function automatic logic [MAG_BITS-1:0] sine_entry(input int unsigned idx,
                                                       input int unsigned addr_bits);
        longint x;
        longint term;
        longint sum;
        longint v;
        x    = (longint'(idx) * HALF_PI_Q30) >>> addr_bits;
        term = x;
        sum  = x;
        for (int k = 0; k < TAYLOR_TERMS; k++)
        begin
            term = (term * x) >>> 30;
            term = (term * x) >>> 30;
            term = term / TAYLOR_DIV[k];
            if ((k % 2) == 0)
                sum = sum - term;
            else
                sum = sum + term;
        end
        if (sum < 0)
            sum = 0;
        v = (sum * 64'sd32767 + (64'sd1 <<< 29)) >>> 30;
        if (v > 64'sd32767)
            v = 64'sd32767;
        return MAG_BITS'(v);
    endfunction

endpackage

// ===== src/tsl_sine_rom.sv =====
// ----------------------------------------------------------------------------
// tsl_sine_rom
// quarter-wave sine magnitude table with registered read
// ----------------------------------------------------------------------------
module tsl_sine_rom #(
    parameter int unsigned ADDR_BITS = tsl_pkg::SINE_ADDR_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         en,
    input  logic [ADDR_BITS:0]           addr,
    output logic [tsl_pkg::MAG_BITS-1:0] data
);
    import tsl_pkg::*;

    localparam int unsigned DEPTH = (1 << ADDR_BITS) + 1;

    logic [MAG_BITS-1:0] table_w [DEPTH];
    logic [MAG_BITS-1:0] data_reg;

    for (genvar gi = 0; gi < DEPTH; gi++)
    begin : g_entry
        assign table_w[gi] = sine_entry(gi, ADDR_BITS);
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= table_w[addr];
    end

    assign data = data_reg;

endmodule

// ===== src/tsl_ramp_div.sv =====
// ----------------------------------------------------------------------------
// tsl_ramp_div
// restoring divider, one quotient bit per cycle, for the ramp step size
// ----------------------------------------------------------------------------
module tsl_ramp_div (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  tsl_pkg::div_ctrl_t                   ctrl,
    input  logic [tsl_pkg::PHASE_BITS-1:0]       dividend,
    input  logic [tsl_pkg::RAMP_BITS-1:0]        divisor,
    output tsl_pkg::div_status_t                 status,
    output logic [tsl_pkg::PHASE_BITS-1:0]       quotient
);
    import tsl_pkg::*;

    localparam int unsigned CNT_BITS = $clog2(PHASE_BITS);

    logic                  busy_reg;
    logic                  done_reg;
    logic [CNT_BITS-1:0]   cnt_reg;
    logic [RAMP_BITS-1:0]  rem_reg;
    logic [PHASE_BITS-1:0] quo_reg;
    logic [RAMP_BITS-1:0]  dvs_reg;

    logic [RAMP_BITS:0]    trial;
    logic [RAMP_BITS:0]    trial_diff;
    logic                  fits;
    logic [RAMP_BITS-1:0]  rem_next;

    // shift the next dividend bit into the partial remainder
    assign trial      = {rem_reg, quo_reg[PHASE_BITS-1]};
    assign trial_diff = trial - {1'b0, dvs_reg};
    assign fits       = (trial >= {1'b0, dvs_reg});
    assign rem_next   = fits ? trial_diff[RAMP_BITS-1:0] : trial[RAMP_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (ctrl.cancel)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (ctrl.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_BITS'(PHASE_BITS - 1);
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
            else
                cnt_reg <= cnt_reg - 1'b1;
        end
        else
            done_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[PHASE_BITS-2:0], fits};
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = quo_reg;

endmodule

// ===== src/tempo_synced_lfo_core.sv =====
// ----------------------------------------------------------------------------
// tempo_synced_lfo_core
// sine lfo on a 32-bit phase accumulator with ramped increment changes, or a
// tempo-locked pulse taken from the host beat position
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  in       in         in_valid / in_stall  beat_position, host_playing
//  out      out        out_valid / out_stall lfo_value
//  cfg      in         cfg_write            cfg_index, cfg_data
//
//  one item per cycle sustained unless out_stall or the divider holds the input;
//  a result passes the table read register, then the output register
//  a phase_step write that starts a ramp runs a bit-serial divider: in_stall
//  stays high while the divider is busy and while its quotient is loaded
//  out_stall holds the output register; in_stall follows once both stages fill
//  reset sets control and config registers to their documented values; data registers are not reset; no clearing pass
// ----------------------------------------------------------------------------
module tempo_synced_lfo_core #(
    parameter int unsigned SINE_ADDR_BITS = tsl_pkg::SINE_ADDR_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic [tsl_pkg::PHASE_BITS-1:0]         beat_position,
    input  logic                                   host_playing,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [tsl_pkg::VALUE_BITS-1:0]  lfo_value,
    input  logic                                   cfg_write,
    input  logic [tsl_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [tsl_pkg::CFG_DATA_BITS-1:0]      cfg_data
);
    import tsl_pkg::*;

    localparam logic [SINE_ADDR_BITS:0] QTR_IDX = (SINE_ADDR_BITS + 1)'(1) << SINE_ADDR_BITS;

    // configuration and oscillator state
    logic [MODE_BITS-1:0]   rate_mode_reg,    rate_mode_next;
    logic [STEP_BITS-1:0]   phase_step_reg,   phase_step_next;
    logic [RAMP_BITS-1:0]   ramp_samples_reg, ramp_samples_next;
    logic [PHASE_BITS-1:0]  phase_acc_reg,    phase_acc_next;
    logic [PHASE_BITS-1:0]  cur_inc_reg,      cur_inc_next;
    logic [PHASE_BITS:0]    ramp_delta_reg,   ramp_delta_next;
    logic [RAMP_BITS-1:0]   ramp_left_reg,    ramp_left_next;
    logic                   div_neg_reg,      div_neg_next;

    // pipeline
    logic                   s1_valid_reg,     s1_valid_next;
    logic                   s1_sine_reg;
    logic                   s1_neg_reg;
    logic                   s1_pulse_reg;
    logic                   out_valid_reg,    out_valid_next;
    logic [VALUE_BITS-1:0]  lfo_value_reg;

    logic                   accept;
    logic                   s2_free;
    logic                   s1_free;
    logic                   s1_move;

    logic [SINE_ADDR_BITS-1:0] tab_j;
    logic [SINE_ADDR_BITS:0]   tab_addr;
    logic [MAG_BITS-1:0]       tab_mag;
    logic                      pulse;
    logic                      is_sine;
    logic [RAMP_BITS-1:0]      left_dec;
    logic [PHASE_BITS-1:0]     inc_stepped;
    logic [VALUE_BITS-1:0]     sine_value;

    logic [PHASE_BITS:0]       step_diff;
    logic [PHASE_BITS:0]       step_diff_neg;
    logic [PHASE_BITS-1:0]     div_dividend;
    logic [STEP_BITS-1:0]      cfg_step;
    logic [PHASE_BITS-1:0]     div_quotient;
    logic [PHASE_BITS:0]       quo_ext;
    div_ctrl_t                 div_ctrl;
    div_status_t               div_status;

    // ------------------------------------------------------------ handshake
    assign s2_free  = !out_valid_reg || !out_stall;
    assign s1_free  = !s1_valid_reg || s2_free;
    assign s1_move  = s1_valid_reg && s2_free;
    assign in_stall = !s1_free || div_status.busy || div_status.done;
    assign accept   = in_valid && !in_stall;

    assign s1_valid_next  = accept || (s1_valid_reg && !s2_free);
    assign out_valid_next = s1_move || (out_valid_reg && out_stall);

    // ------------------------------------------------------------ table address
    assign tab_j    = phase_acc_reg[PHASE_BITS-3 -: SINE_ADDR_BITS];
    assign tab_addr = phase_acc_reg[PHASE_BITS-2] ? (QTR_IDX - {1'b0, tab_j})
                                                  : {1'b0, tab_j};

    tsl_sine_rom #(
        .ADDR_BITS (SINE_ADDR_BITS)
    ) u_rom (
        .clk  (clk),
        .en   (accept),
        .addr (tab_addr),
        .data (tab_mag)
    );

    // ------------------------------------------------------------ tempo pulse
    always_comb
    begin
        is_sine = 1'b0;
        pulse   = 1'b0;
        case (rate_mode_reg)
            MODE_FREE:      is_sine = 1'b1;
            MODE_WHOLE:     pulse   = host_playing && !beat_position[17];
            MODE_HALF:      pulse   = host_playing && !beat_position[16];
            MODE_QUARTER:   pulse   = host_playing && !beat_position[15];
            MODE_EIGHTH:    pulse   = host_playing && !beat_position[14];
            MODE_SIXTEENTH: pulse   = host_playing && !beat_position[13];
            default:        pulse   = 1'b0;
        endcase
    end

    // ------------------------------------------------------------ ramp and config
    assign left_dec      = ramp_left_reg - 1'b1;
    assign inc_stepped   = cur_inc_reg + ramp_delta_reg[PHASE_BITS-1:0];
    assign cfg_step      = cfg_data[STEP_BITS-1:0];
    assign step_diff     = {2'b00, cfg_step} - {1'b0, cur_inc_reg};
    assign step_diff_neg = -step_diff;
    assign div_dividend  = step_diff[PHASE_BITS] ? step_diff_neg[PHASE_BITS-1:0]
                                                 : step_diff[PHASE_BITS-1:0];
    assign quo_ext       = {1'b0, div_quotient};

    always_comb
    begin
        rate_mode_next    = rate_mode_reg;
        phase_step_next   = phase_step_reg;
        ramp_samples_next = ramp_samples_reg;
        phase_acc_next    = phase_acc_reg;
        cur_inc_next      = cur_inc_reg;
        ramp_delta_next   = ramp_delta_reg;
        ramp_left_next    = ramp_left_reg;
        div_neg_next      = div_neg_reg;
        div_ctrl.start    = 1'b0;
        div_ctrl.cancel   = 1'b0;

        // free-running tick: one ramp step, then advance the phase
        if (accept && is_sine)
        begin
            if (ramp_left_reg != '0)
            begin
                ramp_left_next = left_dec;
                if (left_dec != '0)
                    cur_inc_next = inc_stepped;
                else
                    cur_inc_next = {1'b0, phase_step_reg};
            end
            phase_acc_next = phase_acc_reg + cur_inc_next;
        end

        if (div_status.done)
            ramp_delta_next = div_neg_reg ? -quo_ext : quo_ext;

        if (cfg_write)
        begin
            case (cfg_index)
                REG_RATE_MODE:
                    rate_mode_next = cfg_data[MODE_BITS-1:0];
                REG_PHASE_STEP:
                begin
                    if (cfg_step != phase_step_reg)
                    begin
                        phase_step_next = cfg_step;
                        if (ramp_samples_reg == '0)
                        begin
                            cur_inc_next    = {1'b0, cfg_step};
                            ramp_left_next  = '0;
                            div_ctrl.cancel = 1'b1;
                        end
                        else
                        begin
                            ramp_left_next = ramp_samples_reg;
                            div_neg_next   = step_diff[PHASE_BITS];
                            div_ctrl.start = 1'b1;
                        end
                    end
                end
                REG_RAMP_SAMPLES:
                    ramp_samples_next = cfg_data[RAMP_BITS-1:0];
                default:
                    rate_mode_next = rate_mode_reg;
            endcase
        end
    end

    tsl_ramp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (div_ctrl),
        .dividend (div_dividend),
        .divisor  (ramp_samples_reg),
        .status   (div_status),
        .quotient (div_quotient)
    );

    // ------------------------------------------------------------ output value
    assign sine_value = s1_neg_reg ? (VALUE_BITS'(0) - {1'b0, tab_mag}) : {1'b0, tab_mag};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_mode_reg    <= MODE_FREE;
            phase_step_reg   <= PHASE_STEP_RESET;
            ramp_samples_reg <= RAMP_SAMPLES_RESET;
            phase_acc_reg    <= '0;
            cur_inc_reg      <= {1'b0, PHASE_STEP_RESET};
            ramp_delta_reg   <= '0;
            ramp_left_reg    <= '0;
            div_neg_reg      <= 1'b0;
            s1_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            rate_mode_reg    <= rate_mode_next;
            phase_step_reg   <= phase_step_next;
            ramp_samples_reg <= ramp_samples_next;
            phase_acc_reg    <= phase_acc_next;
            cur_inc_reg      <= cur_inc_next;
            ramp_delta_reg   <= ramp_delta_next;
            ramp_left_reg    <= ramp_left_next;
            div_neg_reg      <= div_neg_next;
            s1_valid_reg     <= s1_valid_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_sine_reg  <= is_sine;
            s1_neg_reg   <= phase_acc_reg[PHASE_BITS-1];
            s1_pulse_reg <= pulse;
        end
        if (s1_move)
        begin
            if (s1_sine_reg)
                lfo_value_reg <= sine_value;
            else
                lfo_value_reg <= s1_pulse_reg ? FULL_SCALE : '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign lfo_value = $signed(lfo_value_reg);

endmodule

// ===== verif/tb_tempo_synced_lfo_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tempo_synced_lfo_core
// Self-checking bench for the lfo core. A tick-level tracker follows the
// phase accumulator, the ramped increment and the tempo pulse. It predicts
// one value per accepted tick and checks every output item in order. There
// is a short directed part, then phases of random ticks under random
// register settings. Both sides stall in random bursts, and the receiver
// holds off long enough to back the block up.
// ----------------------------------------------------------------------------

class lfo_tracker;

    localparam int ADDR_BITS = tsl_pkg::SINE_ADDR_BITS_DEF;
    localparam int QTR_SIZE  = 1 << ADDR_BITS;
    localparam longint QUARTER_TURN_Q30 = 64'd1686629713;
    localparam int NOTE_BIT_BASE = 18;
    localparam int REPORT_LIMIT  = 10;

    logic [2:0]  rate_mode;
    logic [30:0] target_step;
    logic [7:0]  ramp_len;
    logic [31:0] phase_acc;
    logic [31:0] cur_incr;
    longint      ramp_delta;
    logic [7:0]  ramp_left;

    int quarter_sine [QTR_SIZE + 1];
    logic signed [15:0] expected_lfo [$];
    int failures;

    function new();
        for (int i = 0; i <= QTR_SIZE; i++)
            quarter_sine[i] = sine_mag(i);
        failures    = 0;
        rate_mode   = tsl_pkg::MODE_FREE;
        target_step = tsl_pkg::PHASE_STEP_RESET;
        ramp_len    = tsl_pkg::RAMP_SAMPLES_RESET;
        phase_acc   = '0;
        cur_incr    = {1'b0, tsl_pkg::PHASE_STEP_RESET};
        ramp_delta  = 0;
        ramp_left   = '0;
    endfunction

    // taylor series to x^13 in q30, then scaled to q15 with rounding
    function int sine_mag(int unsigned idx);
        longint x;
        longint term;
        longint acc;
        longint scaled;
        int k;
        x    = (longint'(idx) * QUARTER_TURN_Q30) >>> ADDR_BITS;
        term = x;
        acc  = x;
        for (k = 1; k <= 6; k++)
        begin
            term = (term * x) >>> 30;
            term = (term * x) >>> 30;
            term = term / longint'((2 * k) * (2 * k + 1));
            if (k % 2 == 1)
                acc = acc - term;
            else
                acc = acc + term;
        end
        if (acc < 0)
            acc = 0;
        scaled = (acc * 32767 + (64'sd1 <<< 29)) >>> 30;
        if (scaled > 32767)
            scaled = 32767;
        return int'(scaled);
    endfunction

    function void write_register(logic [1:0] idx, logic [30:0] data);
        if (idx == tsl_pkg::REG_RATE_MODE)
            rate_mode = data[2:0];
        else if (idx == tsl_pkg::REG_PHASE_STEP)
        begin
            if (data != target_step)
            begin
                target_step = data;
                if (ramp_len == 0)
                begin
                    cur_incr  = {1'b0, data};
                    ramp_left = '0;
                end
                else
                begin
                    ramp_delta = (longint'(data) - longint'(cur_incr)) / longint'(ramp_len);
                    ramp_left  = ramp_len;
                end
            end
        end
        else if (idx == tsl_pkg::REG_RAMP_SAMPLES)
            ramp_len = data[7:0];
    endfunction

    function void note_tick(logic [31:0] beat, logic playing);
        int value;
        int mag;
        int unsigned slot;
        logic [1:0] quad;
        value = 0;
        if (rate_mode == tsl_pkg::MODE_FREE)
        begin
            quad = phase_acc[31:30];
            slot = (phase_acc >> (30 - ADDR_BITS)) & 32'(QTR_SIZE - 1);
            mag  = quad[0] ? quarter_sine[QTR_SIZE - slot] : quarter_sine[slot];
            value = quad[1] ? -mag : mag;
            if (ramp_left != 0)
            begin
                ramp_left = ramp_left - 8'd1;
                if (ramp_left != 0)
                    cur_incr = 32'(longint'(cur_incr) + ramp_delta);
                else
                    cur_incr = {1'b0, target_step};
            end
            phase_acc = phase_acc + cur_incr;
        end
        else if (rate_mode <= tsl_pkg::MODE_SIXTEENTH)
        begin
            // first half of the note length is the high part of the pulse
            if (playing && !beat[NOTE_BIT_BASE - int'(rate_mode)])
                value = int'(tsl_pkg::FULL_SCALE);
        end
        expected_lfo.push_back(16'(value));
    endfunction

    function void check_value(logic signed [15:0] actual);
        logic signed [15:0] want;
        if (expected_lfo.size() == 0)
        begin
            if (failures < REPORT_LIMIT)
                $display("unexpected lfo item: got %0d", actual);
            failures++;
            return;
        end
        want = expected_lfo.pop_front();
        if (actual !== want)
        begin
            if (failures < REPORT_LIMIT)
                $display("lfo_value mismatch: expected %0d, got %0d", want, actual);
            failures++;
        end
    endfunction

    function void close_out();
        if (expected_lfo.size() != 0)
        begin
            if (failures < REPORT_LIMIT)
                $display("%0d lfo items never arrived", expected_lfo.size());
            failures++;
        end
    endfunction

endclass

module tb_tempo_synced_lfo_core;

    import tsl_pkg::*;

    localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED = 2'd3;
    localparam logic [MODE_BITS-1:0] MODE_SPARE_LO = 3'd6;
    localparam logic [MODE_BITS-1:0] MODE_SPARE_HI = 3'd7;
    localparam int NOTE_BIT_BASE  = 18;
    localparam int NUM_PHASES     = 16;
    localparam int LONG_HOLD      = 600;
    localparam int WATCHDOG_LIMIT = 4000;

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_stall;
    logic [PHASE_BITS-1:0]         beat_position;
    logic                          host_playing;
    logic                          out_valid;
    logic                          out_stall;
    logic signed [VALUE_BITS-1:0]  lfo_value;
    logic                          cfg_write;
    logic [CFG_INDEX_BITS-1:0]     cfg_index;
    logic [CFG_DATA_BITS-1:0]      cfg_data;

    lfo_tracker sb;
    logic idle_on;
    logic long_hold_req;

    tempo_synced_lfo_core u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .beat_position (beat_position),
        .host_playing  (host_playing),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .lfo_value     (lfo_value),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // one item offered and held until taken; valid stays high into the next
    task automatic drive_item(input logic [31:0] beat, input logic playing);
        int gap;
        if (idle_on && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 19);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid      <= 1'b1;
        beat_position <= beat;
        host_playing  <= playing;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        sb.note_tick(beat, playing);
        @(negedge clk);
    endtask

    // drop valid and wait for every predicted item to come back
    task automatic settle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.expected_lfo.size() != 0);
        @(negedge clk);
    endtask

    task automatic cfg_set(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        sb.write_register(idx, data);
        @(negedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
    endtask

    // phase_step goes last so no write lands while the divider runs
    task automatic random_config();
        logic [MODE_BITS-1:0] mode;
        logic [STEP_BITS-1:0] step;
        logic [RAMP_BITS-1:0] ramp;
        if ($urandom_range(0, 1) == 0)
            mode = MODE_FREE;
        else
            mode = MODE_BITS'($urandom_range(MODE_WHOLE, MODE_SIXTEENTH));
        cfg_set(REG_RATE_MODE, CFG_DATA_BITS'(mode));
        if ($urandom_range(0, 1) == 0)
        begin
            case ($urandom_range(0, 5))
                0: ramp = '0;
                1: ramp = '1;
                2: ramp = 8'd1;
                default: ramp = RAMP_BITS'($urandom_range(2, 40));
            endcase
            cfg_set(REG_RAMP_SAMPLES, CFG_DATA_BITS'(ramp));
        end
        if ($urandom_range(0, 3) != 0)
        begin
            case ($urandom_range(0, 5))
                0: step = '0;
                1: step = '1;
                2: step = STEP_BITS'($urandom_range(1, 2000000));
                default: step = STEP_BITS'($urandom());
            endcase
            cfg_set(REG_PHASE_STEP, step);
        end
    endtask

    // mostly a running transport position, with some scattered noise ticks
    task automatic random_phase(input int n);
        logic [31:0] beat_run;
        logic [31:0] beat_step;
        logic [31:0] beat;
        logic        playing;
        beat_run  = $urandom();
        beat_step = $urandom_range(1, 16384);
        repeat (n)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                beat_run = beat_run + beat_step;
                beat     = beat_run;
                playing  = ($urandom_range(0, 15) != 0);
            end
            else
            begin
                beat    = $urandom();
                playing = $urandom_range(0, 1);
            end
            drive_item(beat, playing);
        end
        settle();
    endtask

    // receiver stall bursts, plus the long hold-off on request
    initial
    begin : receiver
        int stall_left;
        stall_left = 0;
        out_stall  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                stall_left    = LONG_HOLD;
            end
            else if (stall_left == 0 && idle_on && $urandom_range(0, 11) == 0)
                stall_left = $urandom_range(1, 19);
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
            sb.check_value(lfo_value);
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb_tempo_synced_lfo_core NOT OK");
        $finish;
    end

    initial
    begin : stimulus
        logic [MODE_BITS-1:0] m;
        int note_bit;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        beat_position = '0;
        host_playing  = 1'b0;
        cfg_write     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        idle_on       = 1'b1;
        long_hold_req = 1'b0;
        sb = new();
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings, free sine
        drive_item(32'h0000_0000, 1'b0);
        drive_item(32'hFFFF_FFFF, 1'b1);
        settle();

        // quarter-turn jump with no ramp walks through every quadrant
        cfg_set(REG_RAMP_SAMPLES, '0);
        cfg_set(REG_PHASE_STEP, 31'h4000_0000);
        repeat (4)
            drive_item($urandom(), $urandom_range(0, 1));
        settle();

        // rewrite of the same step and a write to the unused index change nothing
        cfg_set(REG_PHASE_STEP, 31'h4000_0000);
        cfg_set(REG_UNUSED, '1);
        drive_item($urandom(), 1'b1);
        settle();

        // short ramp up to the largest step, ending exactly on target
        cfg_set(REG_RAMP_SAMPLES, 31'd4);
        cfg_set(REG_PHASE_STEP, '1);
        repeat (4)
            drive_item($urandom(), 1'b1);
        settle();

        // ramp down to zero, with the ramp length changed part way through
        cfg_set(REG_PHASE_STEP, '0);
        drive_item($urandom(), 1'b0);
        settle();
        cfg_set(REG_RAMP_SAMPLES, 31'd255);
        repeat (3)
            drive_item($urandom(), 1'b1);
        settle();

        // each note length: the note bit clear with all others set, then only the note bit set
        for (m = MODE_WHOLE; m <= MODE_SIXTEENTH; m++)
        begin
            note_bit = NOTE_BIT_BASE - int'(m);
            cfg_set(REG_RATE_MODE, CFG_DATA_BITS'(m));
            drive_item(~(32'd1 << note_bit), 1'b1);
            drive_item(32'd1 << note_bit, 1'b1);
            settle();
        end

        // spare modes give zero
        cfg_set(REG_RATE_MODE, CFG_DATA_BITS'(MODE_SPARE_LO));
        drive_item(32'h0000_0000, 1'b1);
        settle();
        cfg_set(REG_RATE_MODE, CFG_DATA_BITS'(MODE_SPARE_HI));
        drive_item(32'h0000_0000, 1'b1);
        settle();

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            idle_on = (ph < NUM_PHASES - 3);
            if (ph == 3 || ph == 9)
                long_hold_req = 1'b1;
            random_config();
            random_phase($urandom_range(70, 130));
        end

        // allow for any stray item still in the two-stage pipe
        repeat (8) @(posedge clk);
        sb.close_out();
        if (sb.failures == 0)
            $display("tb_tempo_synced_lfo_core OK");
        else
            $display("tb_tempo_synced_lfo_core NOT OK");
        $finish;
    end

endmodule
